// File: src/atk_pkg.sv
// Shared types, constants and residue helpers for the Atkin prime counter.
// Used by atk_seq, atk_alu, atk_mem and the top level; depends on nothing.
package atk_pkg;

  localparam int unsigned MaxLimitDef = 65535;
  localparam int unsigned CntW        = 16;
  localparam int unsigned LimW        = 16;
  localparam int unsigned ResW        = 4;

  // residues mod 12 that select a toggle for each quadratic form
  localparam logic [ResW-1:0] ResFourA  = 4'd1;
  localparam logic [ResW-1:0] ResFourB  = 4'd5;
  localparam logic [ResW-1:0] ResThreeP = 4'd7;
  localparam logic [ResW-1:0] ResThreeM = 4'd11;
  localparam logic [ResW-1:0] ModLast   = 4'd11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FORM,
    ST_TOGGLE,
    ST_ADV_Y,
    ST_ADV_X,
    ST_TRIPLE,
    ST_SQ_TEST,
    ST_SQ_CHECK,
    ST_SQ_CLEAR,
    ST_SQ_NEXT,
    ST_COUNT,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    FORM_FOUR,
    FORM_THREE_P,
    FORM_THREE_M
  } form_e;

  function automatic form_e form_next(form_e f);
    form_e g;
    case (f)
      FORM_FOUR:    g = FORM_THREE_P;
      FORM_THREE_P: g = FORM_THREE_M;
      default:      g = FORM_FOUR;
    endcase
    return g;
  endfunction

  // square of a residue, reduced mod 12
  function automatic logic [ResW-1:0] sq_mod12(logic [ResW-1:0] m);
    logic [ResW-1:0] s;
    case (m)
      4'd0, 4'd6:              s = 4'd0;
      4'd1, 4'd5, 4'd7, 4'd11: s = 4'd1;
      4'd2, 4'd4, 4'd8, 4'd10: s = 4'd4;
      4'd3, 4'd9:              s = 4'd9;
      default:                 s = 4'd0;
    endcase
    return s;
  endfunction

  // reduce a value below 60 mod 12 by three compare-subtract steps
  function automatic logic [ResW-1:0] mod12_small(logic [5:0] v);
    logic [5:0] t;
    t = v;
    if (t >= 6'd48) t = t - 6'd48;
    if (t >= 6'd24) t = t - 6'd24;
    if (t >= 6'd12) t = t - 6'd12;
    return t[ResW-1:0];
  endfunction

  // residue test of one form, from x mod 12 and y mod 12
  function automatic logic form_res_ok(form_e f, logic [ResW-1:0] x12,
                                       logic [ResW-1:0] y12);
    logic [5:0]      xm;
    logic [5:0]      ym;
    logic [ResW-1:0] r;
    logic            ok;
    xm = 6'(sq_mod12(x12));
    ym = 6'(sq_mod12(y12));
    case (f)
      FORM_FOUR: begin
        r  = mod12_small((xm << 2) + ym);
        ok = (r == ResFourA) || (r == ResFourB);
      end
      FORM_THREE_P: begin
        r  = mod12_small((xm << 1) + xm + ym);
        ok = (r == ResThreeP);
      end
      default: begin
        r  = mod12_small((xm << 1) + xm + 6'd12 - ym);
        ok = (r == ResThreeM);
      end
    endcase
    return ok;
  endfunction

endpackage

// File: src/atkin_prime_counter.sv
// Top level of the Atkin prime counter: sequencer, shared adder, bit store.
// Depends on atk_pkg, atk_seq, atk_alu and atk_mem.
//
//   channel | direction | word          | handshake
//   limit   | in        | limit_i       | in_valid_i / in_ready_o
//   count   | out       | prime_count_o | out_valid_o / out_ready_i
//
// Run time grows with the limit L; a limit L < 2 goes straight to the output.
// The shared adder and the one-bit store, one access per cycle, set the work:
// a clear pass over 0..L, form tests and toggles per (x, y) pair, an advance
// per x, a test per r plus a clear per multiple of r*r, then the count pass.
// in_ready_o is high only while idle; a finished count waits in the output
// register and the next limit may be taken meanwhile.
// Reset clears the sequencer state and the output valid; the store needs no reset.
module atkin_prime_counter import atk_pkg::*; #(
  parameter int unsigned MAX_LIMIT = MaxLimitDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [LimW-1:0] limit_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CntW-1:0] prime_count_o
);

  localparam int unsigned LW = $clog2(MAX_LIMIT + 1);
  localparam int unsigned NW = LW + 3;
  localparam int unsigned RW = (LW + 1) / 2 + 1;

  logic [NW-1:0] alu_a, alu_b, alu_lim, alu_sum;
  logic          alu_sub, alu_gt;
  logic          mem_we, mem_wdata, mem_re, mem_rdata;
  logic [LW-1:0] mem_waddr, mem_raddr;

  atk_seq #(
    .MAX_LIMIT(MAX_LIMIT),
    .LW       (LW),
    .NW       (NW),
    .RW       (RW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .limit_i      (limit_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .prime_count_o(prime_count_o),
    .alu_a_o      (alu_a),
    .alu_b_o      (alu_b),
    .alu_sub_o    (alu_sub),
    .alu_lim_o    (alu_lim),
    .alu_sum_i    (alu_sum),
    .alu_gt_i     (alu_gt),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  atk_alu #(
    .W(NW)
  ) u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .sub_i(alu_sub),
    .lim_i(alu_lim),
    .sum_o(alu_sum),
    .gt_o (alu_gt)
  );

  atk_mem #(
    .DEPTH(MAX_LIMIT + 1),
    .AW   (LW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

// File: src/atk_alu.sv
// Shared add/subtract unit with a compare against the active limit.
// The candidates, the squares and the stepping store addresses are formed here; uses atk_pkg.
module atk_alu import atk_pkg::*; #(
  parameter int unsigned W = 19
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  input  logic [W-1:0] lim_i,
  output logic [W-1:0] sum_o,
  output logic         gt_o
);

  always_comb begin
    if (sub_i) begin
      sum_o = a_i - b_i;
    end else begin
      sum_o = a_i + b_i;
    end
    gt_o = (sum_o > lim_i);
  end

endmodule

// File: src/atk_mem.sv
// Candidate bit store: one write port, one registered read port.
// Plain single-bit RAM; uses atk_pkg for nothing but house imports.
module atk_mem import atk_pkg::*; #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic store_q [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= store_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/atk_seq.sv
// Sequencer of the prime counter: clear pass, quadratic-form toggles,
// square-multiple clears and the final count. Drives atk_alu and atk_mem.
module atk_seq import atk_pkg::*; #(
  parameter int unsigned MAX_LIMIT = MaxLimitDef,
  parameter int unsigned LW        = 16,
  parameter int unsigned NW        = 19,
  parameter int unsigned RW        = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [LimW-1:0] limit_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CntW-1:0] prime_count_o,
  output logic [NW-1:0]   alu_a_o,
  output logic [NW-1:0]   alu_b_o,
  output logic            alu_sub_o,
  output logic [NW-1:0]   alu_lim_o,
  input  logic [NW-1:0]   alu_sum_i,
  input  logic            alu_gt_i,
  output logic            mem_we_o,
  output logic [LW-1:0]   mem_waddr_o,
  output logic            mem_wdata_o,
  output logic            mem_re_o,
  output logic [LW-1:0]   mem_raddr_o,
  input  logic            mem_rdata_i
);

  state_e          state_q, state_d;
  form_e           form_q, form_d;
  logic [LW-1:0]   lim_q, lim_d, lim_sat;
  logic [LW-1:0]   ptr_q, ptr_d;
  logic [LW-1:0]   n_q, n_d;
  logic [RW-1:0]   x_q, x_d, y_q, y_d, r_q, r_d;
  logic [ResW-1:0] x12_q, x12_d, y12_q, y12_d;
  logic [LW-1:0]   xx_q, xx_d, yy_q, yy_d;
  logic [NW-1:0]   xx3_q, xx3_d, rr_q, rr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic            out_valid_q, out_valid_d;
  logic [CntW-1:0] out_cnt_q, out_cnt_d;
  logic            form_ok;
  logic            accept;
  logic            out_free;

  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign alu_lim_o = NW'(lim_q);

  always_comb begin
    if (32'(limit_i) > 32'(MAX_LIMIT)) begin
      lim_sat = LW'(MAX_LIMIT);
    end else begin
      lim_sat = LW'(limit_i);
    end
  end

  // operand selection for the shared unit
  always_comb begin
    alu_a_o   = '0;
    alu_b_o   = '0;
    alu_sub_o = 1'b0;
    case (state_q)
      ST_CLEAR, ST_COUNT: begin
        alu_a_o = NW'(ptr_q);
        alu_b_o = NW'(1);
      end
      ST_FORM: begin
        case (form_q)
          FORM_FOUR: begin
            alu_a_o = NW'(xx_q) << 2;
            alu_b_o = NW'(yy_q);
          end
          FORM_THREE_P: begin
            alu_a_o = xx3_q;
            alu_b_o = NW'(yy_q);
          end
          default: begin
            alu_a_o   = xx3_q;
            alu_b_o   = NW'(yy_q);
            alu_sub_o = 1'b1;
          end
        endcase
      end
      ST_ADV_Y: begin
        alu_a_o = NW'(yy_q);
        alu_b_o = NW'({y_q, 1'b1});
      end
      ST_ADV_X: begin
        alu_a_o = NW'(xx_q);
        alu_b_o = NW'({x_q, 1'b1});
      end
      ST_TRIPLE: begin
        alu_a_o = NW'(xx_q);
        alu_b_o = NW'(xx_q) << 1;
      end
      ST_SQ_TEST: begin
        alu_a_o = rr_q;
      end
      ST_SQ_CLEAR: begin
        alu_a_o = NW'(ptr_q);
        alu_b_o = rr_q;
      end
      ST_SQ_NEXT: begin
        alu_a_o = rr_q;
        alu_b_o = NW'({r_q, 1'b1});
      end
      default: begin
        alu_a_o = '0;
      end
    endcase
  end

  always_comb begin
    case (form_q)
      FORM_THREE_M: form_ok = (x_q > y_q) && !alu_gt_i &&
                              form_res_ok(form_q, x12_q, y12_q);
      default:      form_ok = !alu_gt_i && form_res_ok(form_q, x12_q, y12_q);
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (lim_sat < LW'(2)) ? ST_DONE : ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (ptr_q == lim_q) state_d = ST_FORM;
      end
      ST_FORM: begin
        if (form_ok) begin
          state_d = ST_TOGGLE;
        end else if (form_q == FORM_THREE_M) begin
          state_d = ST_ADV_Y;
        end
      end
      ST_TOGGLE: begin
        state_d = (form_q == FORM_THREE_M) ? ST_ADV_Y : ST_FORM;
      end
      ST_ADV_Y: begin
        state_d = alu_gt_i ? ST_ADV_X : ST_FORM;
      end
      ST_ADV_X: begin
        state_d = alu_gt_i ? ST_SQ_TEST : ST_TRIPLE;
      end
      ST_TRIPLE: begin
        state_d = ST_FORM;
      end
      ST_SQ_TEST: begin
        if (alu_gt_i) begin
          state_d = (lim_q < LW'(5)) ? ST_DONE : ST_COUNT;
        end else begin
          state_d = ST_SQ_CHECK;
        end
      end
      ST_SQ_CHECK: begin
        state_d = mem_rdata_i ? ST_SQ_CLEAR : ST_SQ_NEXT;
      end
      ST_SQ_CLEAR: begin
        if (alu_gt_i) state_d = ST_SQ_NEXT;
      end
      ST_SQ_NEXT: begin
        state_d = ST_SQ_TEST;
      end
      ST_COUNT: begin
        if (alu_gt_i) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // datapath and memory controls
  always_comb begin
    form_d      = form_q;
    lim_d       = lim_q;
    ptr_d       = ptr_q;
    n_d         = n_q;
    x_d         = x_q;
    y_d         = y_q;
    r_d         = r_q;
    x12_d       = x12_q;
    y12_d       = y12_q;
    xx_d        = xx_q;
    yy_d        = yy_q;
    xx3_d       = xx3_q;
    rr_d        = rr_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_cnt_d   = out_cnt_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q;
    mem_wdata_o = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          lim_d = lim_sat;
          ptr_d = '0;
          cnt_d = '0;
        end
      end
      ST_CLEAR: begin
        mem_we_o = 1'b1;
        ptr_d    = alu_sum_i[LW-1:0];
        if (ptr_q == lim_q) begin
          x_d    = RW'(1);
          y_d    = RW'(1);
          x12_d  = ResW'(1);
          y12_d  = ResW'(1);
          xx_d   = LW'(1);
          yy_d   = LW'(1);
          xx3_d  = NW'(3);
          form_d = FORM_FOUR;
        end
      end
      ST_FORM: begin
        n_d         = alu_sum_i[LW-1:0];
        mem_raddr_o = alu_sum_i[LW-1:0];
        if (form_ok) begin
          mem_re_o = 1'b1;
        end else if (form_q != FORM_THREE_M) begin
          form_d = form_next(form_q);
        end
      end
      ST_TOGGLE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = n_q;
        mem_wdata_o = !mem_rdata_i;
        if (form_q != FORM_THREE_M) form_d = form_next(form_q);
      end
      ST_ADV_Y: begin
        form_d = FORM_FOUR;
        if (alu_gt_i) begin
          y_d   = RW'(1);
          yy_d  = LW'(1);
          y12_d = ResW'(1);
        end else begin
          y_d   = y_q + RW'(1);
          yy_d  = alu_sum_i[LW-1:0];
          y12_d = (y12_q == ModLast) ? '0 : y12_q + ResW'(1);
        end
      end
      ST_ADV_X: begin
        if (alu_gt_i) begin
          r_d  = RW'(5);
          rr_d = NW'(25);
        end else begin
          x_d   = x_q + RW'(1);
          xx_d  = alu_sum_i[LW-1:0];
          x12_d = (x12_q == ModLast) ? '0 : x12_q + ResW'(1);
        end
      end
      ST_TRIPLE: begin
        xx3_d = alu_sum_i;
      end
      ST_SQ_TEST: begin
        mem_raddr_o = LW'(r_q);
        if (alu_gt_i) begin
          cnt_d = (lim_q >= LW'(3)) ? CntW'(2) : CntW'(1);
          ptr_d = LW'(5);
        end else begin
          mem_re_o = 1'b1;
        end
      end
      ST_SQ_CHECK: begin
        ptr_d = rr_q[LW-1:0];
      end
      ST_SQ_CLEAR: begin
        mem_we_o = 1'b1;
        ptr_d    = alu_sum_i[LW-1:0];
      end
      ST_SQ_NEXT: begin
        rr_d = alu_sum_i;
        r_d  = r_q + RW'(1);
      end
      ST_COUNT: begin
        mem_re_o = 1'b1;
        pend_d   = 1'b1;
        ptr_d    = alu_sum_i[LW-1:0];
        if (pend_q && mem_rdata_i) cnt_d = cnt_q + CntW'(1);
      end
      ST_DRAIN: begin
        if (pend_q && mem_rdata_i) cnt_d = cnt_q + CntW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_cnt_d   = cnt_q;
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    form_q    <= form_d;
    lim_q     <= lim_d;
    ptr_q     <= ptr_d;
    n_q       <= n_d;
    x_q       <= x_d;
    y_q       <= y_d;
    r_q       <= r_d;
    x12_q     <= x12_d;
    y12_q     <= y12_d;
    xx_q      <= xx_d;
    yy_q      <= yy_d;
    xx3_q     <= xx3_d;
    rr_q      <= rr_d;
    cnt_q     <= cnt_d;
    out_cnt_q <= out_cnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign prime_count_o = out_cnt_q;

endmodule

// File: src/atk_chk.sv
// Port-level checker for the Atkin prime counter, bound to the top level.
// Depends on atk_pkg for field widths.
module atk_chk import atk_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic [LimW-1:0] limit_i,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [CntW-1:0] prime_count_o
);

  // an accepted limit keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("limit accepted but block still ready");

  // a count only appears after the block has been working
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while idle");

  // no 16-bit limit has more than 6542 primes at or below it
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (prime_count_o <= 16'd6542))
    else $error("prime count out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(prime_count_o))
    else $error("stalled result word changed");

endmodule

bind atkin_prime_counter atk_chk u_atk_chk (.*);
